### hw/rtl/nrc_pkg.sv
// ----------------------------------------------------------------------------
// nrc_pkg
// Shared constants, codes and state types of the n-gram repeat counter.
// ----------------------------------------------------------------------------
`default_nettype none

package nrc_pkg;

	// default sizes
	localparam int MAX_LEN_DEF       = 16;
	localparam int TABLE_ENTRIES_DEF = 1024;

	// hashing constants
	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [31:0] MIX_C1    = 32'h7feb352d;
	localparam logic [31:0] MIX_C2    = 32'h846ca68b;

	localparam logic [4:0]  LEN_RESET = 5'd4;
	localparam logic [31:0] COUNT_MAX = 32'hffffffff;
	localparam int          TOKEN_W   = 64;
	localparam int          LEN_W     = 5;

	// result status codes
	typedef enum logic [2:0] {
		ST_FILLING = 3'd0,
		ST_NEW     = 3'd1,
		ST_COUNTED = 3'd2,
		ST_FULL    = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	// kinds of work handed from front to back
	typedef enum logic [1:0] {
		JK_FILL   = 2'd0,
		JK_CLEAR  = 2'd1,
		JK_LOOKUP = 2'd2
	} job_kind_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_HASH,
		F_MIX,
		F_MOD,
		F_ENQ
	} fe_state_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_SLOT_RD,
		B_SLOT_CHK,
		B_KEY_RD,
		B_KEY_CHK,
		B_KEY_WR
	} be_state_t;

	// back-end status seen by the top level
	typedef struct packed {
		logic clearing;
		logic busy;
	} be_stat_t;

endpackage

`default_nettype wire

### hw/rtl/ngram_repeat_counter_top.sv
// ----------------------------------------------------------------------------
// ngram_repeat_counter_top
// Counts repeated n-grams of token hashes in an open-addressing table.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         push / full          operation, token, position
// result    out        pop / empty          status, entry_count, first_position,
//                                           unique_count, repeated_count, peak_count
// config    in         cfg_valid/cfg_ready  cfg_data (ngram_length)
//
// Front: takes an item, hashes the window byte-serially with FNV, then
// folds on one multiplier, takes the remainder and queues the work.
// Back: each slot probe is a read and then a check, as is each key word
// compared; an insert writes MAX_LEN key words, one per cycle on the key memory port.
// After reset the slot table is wiped entry by entry; full stays high meanwhile.
// The two halves stall separately through a two-entry work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ngram_repeat_counter_top #(
	parameter int MAX_LEN       = nrc_pkg::MAX_LEN_DEF,
	parameter int TABLE_ENTRIES = nrc_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        operation,
	input  wire logic [63:0] token,
	input  wire logic [31:0] position,
	output logic             empty,
	input  wire logic        pop,
	output logic      [2:0]  status,
	output logic      [31:0] entry_count,
	output logic      [31:0] first_position,
	output logic      [10:0] unique_count,
	output logic      [10:0] repeated_count,
	output logic      [31:0] peak_count,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  cfg_data
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int JW = MAX_LEN * 64 + 64 + 32 + 5 + IW + 2;

	logic          job_wr, job_full, job_rd, job_valid;
	logic [JW-1:0] job_wdata, job_rdata;
	nrc_pkg::be_stat_t be_stat;

	assign cfg_ready = 1'b1;

	nrc_front #(.MAX_LEN(MAX_LEN), .TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.hold      (be_stat.clearing),
		.full      (full),
		.operation (operation),
		.token     (token),
		.position  (position),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.job_wr    (job_wr),
		.job_data  (job_wdata),
		.job_full  (job_full)
	);

	nrc_jobq #(.WIDTH(JW)) u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (job_wr),
		.wdata   (job_wdata),
		.q_full  (job_full),
		.rd      (job_rd),
		.q_valid (job_valid),
		.rdata   (job_rdata)
	);

	nrc_back #(.MAX_LEN(MAX_LEN), .TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.job_valid      (job_valid),
		.job_rd         (job_rd),
		.job_data       (job_rdata),
		.pop            (pop),
		.empty          (empty),
		.status         (status),
		.entry_count    (entry_count),
		.first_position (first_position),
		.unique_count   (unique_count),
		.repeated_count (repeated_count),
		.peak_count     (peak_count),
		.stat           (be_stat)
	);

	// no item may enter while the table is being wiped
	assert property (@(posedge clk) disable iff (!arst_n)
		be_stat.clearing |-> full)
		else $error("item window open during table wipe");

	// a taken item leaves the front busy in the following cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> full)
		else $error("front took two items back to back");

	// a waiting result always carries a defined status code
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (status <= 3'(nrc_pkg::ST_CLEARED)))
		else $error("result status out of range");

	// a result on show implies the back end is not idle-free
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> be_stat.busy)
		else $error("result held while back end reports free");

endmodule

`default_nettype wire

### hw/rtl/nrc_ram.sv
// ----------------------------------------------------------------------------
// nrc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module nrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, and register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/nrc_jobq.sv
// ----------------------------------------------------------------------------
// nrc_jobq
// Two-entry queue of work descriptors between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nrc_jobq #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  q_full,
	input  wire logic             rd,
	output logic                  q_valid,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             do_wr, do_rd;

	assign q_full  = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign rdata   = ent_q[rp_q];
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && q_valid;

	// store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wp_q] <= wdata;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wp_q <= ~wp_q;
			if (do_rd) rp_q <= ~rp_q;
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/nrc_front.sv
// ----------------------------------------------------------------------------
// nrc_front
// Front end: takes items, keeps the token window, hashes full windows
// byte by byte, folds and reduces the hash to a start slot, queues the work.
// ----------------------------------------------------------------------------
`default_nettype none

module nrc_front #(
	parameter int MAX_LEN       = nrc_pkg::MAX_LEN_DEF,
	parameter int TABLE_ENTRIES = nrc_pkg::TABLE_ENTRIES_DEF,
	localparam int WIDX = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
	localparam int IW   = $clog2(TABLE_ENTRIES),
	localparam int JW   = MAX_LEN * 64 + 64 + 32 + 5 + IW + 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic          hold,
	output logic               full,
	input  wire logic          operation,
	input  wire logic [63:0]   token,
	input  wire logic [31:0]   position,
	input  wire logic          cfg_wr,
	input  wire logic [4:0]    cfg_data,
	output logic               job_wr,
	output logic      [JW-1:0] job_data,
	input  wire logic          job_full
);

	// floor(2^32 / TABLE_ENTRIES): the quotient estimate is at most one short
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(TABLE_ENTRIES));

	nrc_pkg::fe_state_t state_q, state_nx;

	logic [63:0]   win_q [MAX_LEN];
	logic [4:0]    len_q, fill_q, n;
	logic [9:0]    cnt_q, hash_last, tw;
	logic [2:0]    mstep_q;
	logic [1:0]    mod_step_q;
	logic [63:0]   hash_q, hx, hword;
	logic [7:0]    hbyte;
	logic [31:0]   mul_q, acc_q, h32_q, hi_pre;
	logic [31:0]   rem_q;
	logic [63:0]   prod_q;
	logic [31:0]   pos_q;
	nrc_pkg::job_kind_t kind_q;
	logic          accept;
	logic [4:0]    fill_nx;
	logic [MAX_LEN*64-1:0] tok_flat;

	assign full   = (state_q != nrc_pkg::F_IDLE) || hold;
	assign accept = push && !full;

	// effective n-gram length
	always_comb begin
		if (len_q == 5'd0) begin
			n = 5'd1;
		end else if (7'(len_q) > 7'(MAX_LEN)) begin
			n = 5'(MAX_LEN);
		end else begin
			n = len_q;
		end
	end

	assign fill_nx   = (fill_q < n) ? fill_q + 5'd1 : n;
	assign hash_last = 10'd3 + {2'b00, n, 3'b000};

	// pick the next byte of the key stream: n first, three zero bytes, then tokens
	assign tw    = cnt_q - 10'd4;
	assign hword = win_q[WIDX'(tw[9:3])];
	always_comb begin
		if (cnt_q < 10'd4) begin
			hbyte = (cnt_q == 10'd0) ? {3'b000, n} : 8'd0;
		end else begin
			hbyte = 8'(hword >> {tw[2:0], 3'b000});
		end
	end

	// one FNV-1a step, prime = 2^40 + 0x1b3
	assign hx = hash_q ^ {56'd0, hbyte};

	assign hi_pre = hash_q[63:32] ^ (hash_q[63:32] >> 16);

	// flatten the window for the work descriptor
	always_comb begin
		for (int i = 0; i < MAX_LEN; i++) begin
			tok_flat[i*64 +: 64] = win_q[i];
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			nrc_pkg::F_IDLE: begin
				if (accept) begin
					if (!operation && fill_nx >= n) state_nx = nrc_pkg::F_HASH;
					else                            state_nx = nrc_pkg::F_ENQ;
				end
			end
			nrc_pkg::F_HASH: begin
				if (cnt_q == hash_last) state_nx = nrc_pkg::F_MIX;
			end
			nrc_pkg::F_MIX: begin
				if (mstep_q == 3'd4) state_nx = nrc_pkg::F_MOD;
			end
			nrc_pkg::F_MOD: begin
				if (mod_step_q == 2'd2) state_nx = nrc_pkg::F_ENQ;
			end
			nrc_pkg::F_ENQ: begin
				if (!job_full) state_nx = nrc_pkg::F_IDLE;
			end
			default: state_nx = nrc_pkg::F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		job_wr   = 1'b0;
		job_data = {kind_q, n, pos_q, hash_q, rem_q[IW-1:0], tok_flat};
		unique case (state_q)
			nrc_pkg::F_ENQ: job_wr = !job_full;
			default:        job_wr = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nrc_pkg::F_IDLE;
			len_q   <= nrc_pkg::LEN_RESET;
			fill_q  <= 5'd0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				fill_q <= operation ? 5'd0 : fill_nx;
			end
			// a length write also empties the window
			if (cfg_wr) begin
				len_q  <= cfg_data;
				fill_q <= 5'd0;
			end
		end
	end

	// window shift and datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= operation ? nrc_pkg::JK_CLEAR :
				(fill_nx >= n) ? nrc_pkg::JK_LOOKUP : nrc_pkg::JK_FILL;
			pos_q  <= position;
			hash_q <= nrc_pkg::FNV_BASIS;
			cnt_q  <= 10'd0;
			if (!operation) begin
				for (int i = 0; i < MAX_LEN; i++) begin
					if (fill_q < n) begin
						if (7'(i) == 7'(fill_q)) win_q[i] <= token;
					end else if (7'(i) + 7'd1 < 7'(n)) begin
						win_q[i] <= win_q[(i + 1) % MAX_LEN];
					end else if (7'(i) + 7'd1 == 7'(n)) begin
						win_q[i] <= token;
					end
				end
			end
		end
		case (state_q)
			nrc_pkg::F_HASH: begin
				hash_q  <= (hx << 40) + (hx << 8) + (hx << 7) + (hx << 5)
					+ (hx << 4) + (hx << 1) + hx;
				cnt_q   <= cnt_q + 10'd1;
				mstep_q <= 3'd0;
			end
			nrc_pkg::F_MIX: begin
				mstep_q <= mstep_q + 3'd1;
				case (mstep_q)
					3'd0: mul_q <= 32'((hash_q[31:0] ^ (hash_q[31:0] >> 16))
						* nrc_pkg::MIX_C1);
					3'd1: mul_q <= 32'((mul_q ^ (mul_q >> 15)) * nrc_pkg::MIX_C2);
					3'd2: begin
						acc_q <= mul_q ^ (mul_q >> 16);
						mul_q <= 32'(hi_pre * nrc_pkg::MIX_C1);
					end
					3'd3: mul_q <= 32'((mul_q ^ (mul_q >> 15)) * nrc_pkg::MIX_C2);
					default: begin
						h32_q      <= acc_q ^ mul_q ^ (mul_q >> 16);
						mod_step_q <= 2'd0;
					end
				endcase
			end
			// remainder by the table size: estimate quotient, subtract, correct once
			nrc_pkg::F_MOD: begin
				mod_step_q <= mod_step_q + 2'd1;
				case (mod_step_q)
					2'd0: prod_q <= 64'(h32_q) * 64'(RECIP);
					2'd1: rem_q  <= h32_q - 32'(prod_q[63:32] * 32'(TABLE_ENTRIES));
					default: begin
						if (rem_q >= 32'(TABLE_ENTRIES))
							rem_q <= rem_q - 32'(TABLE_ENTRIES);
					end
				endcase
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/nrc_back.sv
// ----------------------------------------------------------------------------
// nrc_back
// Back end: probes the open-addressing table, compares stored keys word by
// word, inserts or counts, keeps the statistics and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module nrc_back #(
	parameter int MAX_LEN       = nrc_pkg::MAX_LEN_DEF,
	parameter int TABLE_ENTRIES = nrc_pkg::TABLE_ENTRIES_DEF,
	localparam int WIDX = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
	localparam int IW   = $clog2(TABLE_ENTRIES),
	localparam int CW   = IW + 1,
	localparam int KAW  = $clog2(TABLE_ENTRIES * MAX_LEN),
	localparam int SW   = 1 + 64 + 32 + 32,
	localparam int JW   = MAX_LEN * 64 + 64 + 32 + 5 + IW + 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_rd,
	input  wire logic [JW-1:0] job_data,
	input  wire logic          pop,
	output logic               empty,
	output logic      [2:0]    status,
	output logic      [31:0]   entry_count,
	output logic      [31:0]   first_position,
	output logic      [10:0]   unique_count,
	output logic      [10:0]   repeated_count,
	output logic      [31:0]   peak_count,
	output nrc_pkg::be_stat_t  stat
);

	localparam logic [CW+1:0] LOAD_LIM = (CW+2)'(3 * TABLE_ENTRIES);
	localparam int TOK_W = MAX_LEN * 64;

	nrc_pkg::be_state_t state_q, state_nx;

	logic [JW-1:0]   job_q;
	logic [IW-1:0]   idx_q, clr_q;
	logic [IW:0]     step_q;
	logic [WIDX-1:0] word_q;
	logic [CW-1:0]   used_q, rep_q;
	logic [31:0]     hi_q;
	logic            res_valid_q;
	nrc_pkg::status_t res_status_q;
	logic [31:0]     res_count_q, res_fpos_q;

	// descriptor fields
	nrc_pkg::job_kind_t in_kind;
	logic [4:0]      jn;
	logic [31:0]     jpos;
	logic [63:0]     jkh, jtok;

	assign in_kind = nrc_pkg::job_kind_t'(job_data[JW-1 -: 2]);
	assign jn      = job_q[JW-3 -: 5];
	assign jpos    = job_q[JW-8 -: 32];
	assign jkh     = job_q[TOK_W+IW +: 64];
	assign jtok    = job_q[64*word_q +: 64];

	// table storage
	logic            slot_we, key_we;
	logic [IW-1:0]   slot_waddr;
	logic [SW-1:0]   slot_wdata, slot_rdata;
	logic [KAW-1:0]  key_addr;
	logic [63:0]     key_wdata, key_rdata;
	logic            rd_valid;
	logic [63:0]     rd_kh;
	logic [31:0]     rd_fpos, rd_cnt;

	assign rd_valid = slot_rdata[SW-1];
	assign rd_kh    = slot_rdata[SW-2 -: 64];
	assign rd_fpos  = slot_rdata[63:32];
	assign rd_cnt   = slot_rdata[31:0];
	assign key_addr = KAW'(idx_q) * KAW'(MAX_LEN) + KAW'(word_q);

	nrc_ram #(.WIDTH(SW), .DEPTH(TABLE_ENTRIES)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (idx_q),
		.rdata (slot_rdata)
	);

	nrc_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES * MAX_LEN)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_addr),
		.wdata (key_wdata),
		.raddr (key_addr),
		.rdata (key_rdata)
	);

	// probe bookkeeping
	logic        last_step, last_word, load_full;
	logic [31:0] fpos_new, cnt_new;

	assign last_step = (step_q + (IW+1)'(1)) == (IW+1)'(TABLE_ENTRIES);
	assign last_word = (8'(word_q) + 8'd1) == 8'(jn);
	assign load_full = (((CW+2)'(used_q) + (CW+2)'(1)) << 2) >= LOAD_LIM;
	assign fpos_new  = jpos - 32'(jn) + 32'd1;
	assign cnt_new   = (rd_cnt == nrc_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 32'd1;

	// control strobes
	logic        res_load, used_inc, rep_inc, hi_upd, advance;
	nrc_pkg::status_t res_status;
	logic [31:0] res_count, res_fpos, hi_new;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			nrc_pkg::B_CLEAR: begin
				if (clr_q == IW'(TABLE_ENTRIES - 1)) state_nx = nrc_pkg::B_IDLE;
			end
			nrc_pkg::B_IDLE: begin
				if (job_valid && !res_valid_q && in_kind == nrc_pkg::JK_LOOKUP)
					state_nx = nrc_pkg::B_SLOT_RD;
			end
			nrc_pkg::B_SLOT_RD: state_nx = nrc_pkg::B_SLOT_CHK;
			nrc_pkg::B_SLOT_CHK: begin
				if (!rd_valid)          state_nx = load_full ? nrc_pkg::B_IDLE
				                                             : nrc_pkg::B_KEY_WR;
				else if (rd_kh == jkh)  state_nx = nrc_pkg::B_KEY_RD;
				else if (last_step)     state_nx = nrc_pkg::B_IDLE;
				else                    state_nx = nrc_pkg::B_SLOT_RD;
			end
			nrc_pkg::B_KEY_RD: state_nx = nrc_pkg::B_KEY_CHK;
			nrc_pkg::B_KEY_CHK: begin
				if (key_rdata != jtok) state_nx = last_step ? nrc_pkg::B_IDLE
				                                            : nrc_pkg::B_SLOT_RD;
				else if (last_word)    state_nx = nrc_pkg::B_IDLE;
				else                   state_nx = nrc_pkg::B_KEY_RD;
			end
			nrc_pkg::B_KEY_WR: begin
				if (32'(word_q) == 32'(MAX_LEN - 1)) state_nx = nrc_pkg::B_IDLE;
			end
			default: state_nx = nrc_pkg::B_IDLE;
		endcase
	end

	// outputs of each state
	always_comb begin
		job_rd     = 1'b0;
		slot_we    = 1'b0;
		slot_waddr = idx_q;
		slot_wdata = '0;
		key_we     = 1'b0;
		key_wdata  = (8'(word_q) < 8'(jn)) ? jtok : 64'd0;
		res_load   = 1'b0;
		res_status = nrc_pkg::ST_FULL;
		res_count  = 32'd0;
		res_fpos   = 32'd0;
		used_inc   = 1'b0;
		rep_inc    = 1'b0;
		hi_upd     = 1'b0;
		hi_new     = hi_q;
		advance    = 1'b0;
		unique case (state_q)
			nrc_pkg::B_CLEAR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q;
			end
			nrc_pkg::B_IDLE: begin
				if (job_valid && !res_valid_q) begin
					job_rd = 1'b1;
					if (in_kind == nrc_pkg::JK_FILL) begin
						res_load   = 1'b1;
						res_status = nrc_pkg::ST_FILLING;
					end else if (in_kind == nrc_pkg::JK_CLEAR) begin
						res_load   = 1'b1;
						res_status = nrc_pkg::ST_CLEARED;
					end
				end
			end
			nrc_pkg::B_SLOT_CHK: begin
				if (!rd_valid) begin
					res_load = 1'b1;
					if (!load_full) begin
						slot_we    = 1'b1;
						slot_wdata = {1'b1, jkh, fpos_new, 32'd1};
						used_inc   = 1'b1;
						hi_upd     = 1'b1;
						hi_new     = (hi_q == 32'd0) ? 32'd1 : hi_q;
						res_status = nrc_pkg::ST_NEW;
						res_count  = 32'd1;
						res_fpos   = fpos_new;
					end
				end else if (rd_kh != jkh) begin
					advance  = 1'b1;
					res_load = last_step;
				end
			end
			nrc_pkg::B_KEY_CHK: begin
				if (key_rdata != jtok) begin
					advance  = 1'b1;
					res_load = last_step;
				end else if (last_word) begin
					slot_we    = 1'b1;
					slot_wdata = {1'b1, rd_kh, rd_fpos, cnt_new};
					rep_inc    = (rd_cnt == 32'd1);
					hi_upd     = 1'b1;
					hi_new     = (cnt_new > hi_q) ? cnt_new : hi_q;
					res_load   = 1'b1;
					res_status = nrc_pkg::ST_COUNTED;
					res_count  = cnt_new;
					res_fpos   = rd_fpos;
				end
			end
			nrc_pkg::B_KEY_WR: key_we = 1'b1;
			default: begin
			end
		endcase
	end

	// control state and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nrc_pkg::B_CLEAR;
			clr_q       <= '0;
			used_q      <= '0;
			rep_q       <= '0;
			hi_q        <= 32'd0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == nrc_pkg::B_CLEAR) clr_q <= clr_q + IW'(1);
			if (used_inc) used_q <= used_q + CW'(1);
			if (rep_inc)  rep_q  <= rep_q + CW'(1);
			if (hi_upd)   hi_q   <= hi_new;
			if (res_load)                 res_valid_q <= 1'b1;
			else if (pop && res_valid_q)  res_valid_q <= 1'b0;
		end
	end

	// probe position, key word and held result
	always_ff @(posedge clk) begin
		if (job_rd) begin
			job_q  <= job_data;
			idx_q  <= job_data[TOK_W +: IW];
			step_q <= '0;
		end
		if (advance) begin
			step_q <= step_q + (IW+1)'(1);
			idx_q  <= (idx_q == IW'(TABLE_ENTRIES - 1)) ? '0 : idx_q + IW'(1);
		end
		case (state_q)
			nrc_pkg::B_SLOT_CHK: word_q <= '0;
			nrc_pkg::B_KEY_CHK:  word_q <= word_q + WIDX'(1);
			nrc_pkg::B_KEY_WR:   word_q <= word_q + WIDX'(1);
			default: begin
			end
		endcase
		if (res_load) begin
			res_status_q <= res_status;
			res_count_q  <= res_count;
			res_fpos_q   <= res_fpos;
		end
	end

	assign empty          = !res_valid_q;
	assign status         = res_status_q;
	assign entry_count    = res_count_q;
	assign first_position = res_fpos_q;
	assign unique_count   = 11'(used_q);
	assign repeated_count = 11'(rep_q);
	assign peak_count     = hi_q;
	assign stat.clearing  = (state_q == nrc_pkg::B_CLEAR);
	assign stat.busy      = (state_q != nrc_pkg::B_IDLE) || res_valid_q;

endmodule

`default_nettype wire
